// ===== src/i2cms_pkg.sv =====
// shared types, phase codes and command codes of the i2c master bit sequencer
package i2cms_pkg;

    localparam int unsigned PHASE_W = 5;
    localparam int unsigned DELAY_W = 11;

    // command codes
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_STOP      = 3'd2;
    localparam logic [2:0] CMD_WRITE     = 3'd3;
    localparam logic [2:0] CMD_READ_ACK  = 3'd4;
    localparam logic [2:0] CMD_READ_NACK = 3'd5;

    // configuration register indexes
    localparam logic CFG_TICKS_PER_UNIT = 1'b0;
    localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

    localparam logic [7:0] TICKS_PER_UNIT_RESET = 8'd50;
    localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd250;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE      = 5'd0;
    localparam logic [PHASE_W-1:0] PH_ST1       = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST2       = 5'd2;
    localparam logic [PHASE_W-1:0] PH_SP1       = 5'd3;
    localparam logic [PHASE_W-1:0] PH_SP2       = 5'd4;
    localparam logic [PHASE_W-1:0] PH_SP3       = 5'd5;
    localparam logic [PHASE_W-1:0] PH_WR_DATA   = 5'd6;
    localparam logic [PHASE_W-1:0] PH_WR_HIGH   = 5'd7;
    localparam logic [PHASE_W-1:0] PH_WR_LOW    = 5'd8;
    localparam logic [PHASE_W-1:0] PH_ACK_HIGH  = 5'd9;
    localparam logic [PHASE_W-1:0] PH_ACK_POLL  = 5'd10;
    localparam logic [PHASE_W-1:0] PH_RD_HIGH   = 5'd11;
    localparam logic [PHASE_W-1:0] PH_RD_SAMPLE = 5'd12;
    localparam logic [PHASE_W-1:0] PH_RD_LOW    = 5'd13;
    localparam logic [PHASE_W-1:0] PH_AK_DATA   = 5'd14;
    localparam logic [PHASE_W-1:0] PH_AK_HIGH   = 5'd15;
    localparam logic [PHASE_W-1:0] PH_AK_LOW    = 5'd16;
    localparam logic [PHASE_W-1:0] NACK_OFFSET  = 5'd8;

    // bus timing in delay units
    localparam logic [2:0] UNITS_SHORT = 3'd2;
    localparam logic [2:0] UNITS_MID   = 3'd3;
    localparam logic [2:0] UNITS_LONG  = 3'd5;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       sda_in;
    } in_word_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } out_word_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [3:0]         bit_count;
        logic [7:0]         shift;
        logic [DELAY_W-1:0] delay_count;
        logic [7:0]         poll_count;
        logic               scl_level;
        logic               sda_level;
        logic               error_flag;
    } seq_state_t;

    typedef struct packed {
        logic [7:0] ticks_per_unit;
        logic [7:0] ack_poll_limit;
    } seq_cfg_t;

    localparam seq_state_t SEQ_STATE_RESET = '{
        phase:       PH_IDLE,
        bit_count:   4'd0,
        shift:       8'd0,
        delay_count: '0,
        poll_count:  8'd0,
        scl_level:   1'b1,
        sda_level:   1'b1,
        error_flag:  1'b0
    };

    // delay load value: units times ticks per unit
    function automatic logic [DELAY_W-1:0] unit_delay(input logic [2:0] units,
                                                      input logic [7:0] ticks);
        logic [DELAY_W-1:0] product;
        product = DELAY_W'(units) * DELAY_W'(ticks);
        return product;
    endfunction

endpackage

// ===== src/i2c_master_bit_sequencer.sv =====
// i2c master bit sequencer: one input word per bus tick, one result word per input word
//
// input channel (in_valid, in_stall, in_data): each word is one tick of the bus timing;
//   it carries the command, the byte to write and the sampled sda level
// output channel (out_valid, out_stall, out_data): exactly one word per input word, in
//   order, giving scl/sda levels after that tick, busy, done, received byte and error
// config port (cfg_we, cfg_index, cfg_data): index 0 ticks per delay unit, index 1
//   acknowledge poll limit; write only while no word is in flight
// latency: one cycle; a word accepted at one edge has its result in the output register
//   at the next edge (input register, then step logic into the result register)
// throughput: one word per cycle; the sequencer state updates once per word in a
//   single pass of the step logic between the two registers
// stall: when out_stall holds a full result register, the input register holds and
//   in_stall rises in the same cycle; the state does not advance while stalled
// reset: both registers empty, bus lines released high, phase idle, config registers
//   back to 50 ticks per unit and a poll limit of 250
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    seq_cfg_t   cfg;
    seq_state_t state_reg;
    seq_state_t state_next;
    out_word_t  res_next;
    out_word_t  res_reg;
    logic       res_valid_reg;
    in_word_t   in_word_reg;
    logic       in_valid_reg;
    logic       advance;
    logic       in_take;

    i2cms_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cms_step u_step (
        .cur     (state_reg),
        .in_word (in_word_reg),
        .cfg     (cfg),
        .nxt     (state_next),
        .res     (res_next)
    );

    // result register can take a new word
    assign advance  = !res_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= SEQ_STATE_RESET;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= in_data;
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

// ===== src/i2cms_cfg.sv =====
// configuration registers of the i2c master bit sequencer
module i2cms_cfg
    import i2cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output seq_cfg_t   cfg
);

    seq_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_unit <= TICKS_PER_UNIT_RESET;
            cfg_reg.ack_poll_limit <= ACK_POLL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TICKS_PER_UNIT: cfg_reg.ticks_per_unit <= cfg_data;
                CFG_ACK_POLL_LIMIT: cfg_reg.ack_poll_limit <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/i2cms_step.sv =====
// one tick of the bus sequencer: next state and result word from state and input word
module i2cms_step
    import i2cms_pkg::*;
(
    input  seq_state_t cur,
    input  in_word_t   in_word,
    input  seq_cfg_t   cfg,
    output seq_state_t nxt,
    output out_word_t  res
);

    logic               nack;
    logic [PHASE_W-1:0] off;
    logic [PHASE_W-1:0] p;
    logic               done;
    logic [7:0]         rx;
    logic [3:0]         bits_inc;

    assign nack     = (cur.phase >= (PH_RD_HIGH + NACK_OFFSET));
    assign off      = nack ? NACK_OFFSET : '0;
    assign p        = cur.phase - off;
    assign bits_inc = cur.bit_count + 4'd1;

    always_comb
    begin
        nxt  = cur;
        done = 1'b0;
        rx   = 8'd0;
        if (cur.delay_count != '0)
        begin
            nxt.delay_count = cur.delay_count - DELAY_W'(1);
        end
        else if (cur.phase == PH_IDLE)
        begin
            if (in_word.command >= CMD_START && in_word.command <= CMD_READ_NACK)
            begin
                nxt.error_flag = 1'b0;
            end
            priority if (in_word.command == CMD_START)
            begin
                nxt.sda_level   = 1'b1;
                nxt.scl_level   = 1'b1;
                nxt.delay_count = unit_delay(UNITS_LONG, cfg.ticks_per_unit);
                nxt.phase       = PH_ST1;
            end
            else if (in_word.command == CMD_STOP)
            begin
                nxt.scl_level   = 1'b0;
                nxt.sda_level   = 1'b0;
                nxt.delay_count = unit_delay(UNITS_LONG, cfg.ticks_per_unit);
                nxt.phase       = PH_SP1;
            end
            else if (in_word.command == CMD_WRITE)
            begin
                nxt.shift       = in_word.tx_byte;
                nxt.bit_count   = 4'd0;
                nxt.delay_count = unit_delay(UNITS_SHORT, cfg.ticks_per_unit);
                nxt.phase       = PH_WR_DATA;
            end
            else if (in_word.command == CMD_READ_ACK || in_word.command == CMD_READ_NACK)
            begin
                nxt.sda_level   = 1'b1;
                nxt.shift       = 8'd0;
                nxt.bit_count   = 4'd0;
                nxt.delay_count = unit_delay(UNITS_LONG, cfg.ticks_per_unit);
                nxt.phase       = (in_word.command == CMD_READ_NACK) ?
                                  (PH_RD_HIGH + NACK_OFFSET) : PH_RD_HIGH;
            end
            else
            begin
                nxt = cur;
            end
        end
        else
        begin
            unique case (p)
                PH_ST1:
                begin
                    nxt.sda_level   = 1'b0;
                    nxt.delay_count = unit_delay(UNITS_LONG, cfg.ticks_per_unit);
                    nxt.phase       = PH_ST2;
                end
                PH_ST2:
                begin
                    nxt.scl_level = 1'b0;
                    nxt.phase     = PH_IDLE;
                    done          = 1'b1;
                end
                PH_SP1:
                begin
                    nxt.scl_level   = 1'b1;
                    nxt.delay_count = unit_delay(UNITS_LONG, cfg.ticks_per_unit);
                    nxt.phase       = PH_SP2;
                end
                PH_SP2:
                begin
                    nxt.sda_level   = 1'b1;
                    nxt.delay_count = unit_delay(UNITS_LONG, cfg.ticks_per_unit);
                    nxt.phase       = PH_SP3;
                end
                PH_SP3:
                begin
                    nxt.phase = PH_IDLE;
                    done      = 1'b1;
                end
                PH_WR_DATA:
                begin
                    nxt.sda_level   = cur.shift[7];
                    nxt.shift       = {cur.shift[6:0], 1'b0};
                    nxt.delay_count = unit_delay(UNITS_MID, cfg.ticks_per_unit);
                    nxt.phase       = PH_WR_HIGH;
                end
                PH_WR_HIGH:
                begin
                    nxt.scl_level   = 1'b1;
                    nxt.delay_count = unit_delay(UNITS_LONG, cfg.ticks_per_unit);
                    nxt.phase       = PH_WR_LOW;
                end
                PH_WR_LOW:
                begin
                    nxt.scl_level = 1'b0;
                    nxt.bit_count = bits_inc;
                    if (bits_inc < 4'd8)
                    begin
                        nxt.delay_count = unit_delay(UNITS_SHORT, cfg.ticks_per_unit);
                        nxt.phase       = PH_WR_DATA;
                    end
                    else
                    begin
                        // release sda for the slave acknowledge
                        nxt.sda_level   = 1'b1;
                        nxt.delay_count = unit_delay(UNITS_LONG, cfg.ticks_per_unit);
                        nxt.phase       = PH_ACK_HIGH;
                    end
                end
                PH_ACK_HIGH:
                begin
                    nxt.scl_level   = 1'b1;
                    nxt.poll_count  = 8'd0;
                    nxt.delay_count = unit_delay(UNITS_SHORT, cfg.ticks_per_unit);
                    nxt.phase       = PH_ACK_POLL;
                end
                PH_ACK_POLL:
                begin
                    priority if (!in_word.sda_in)
                    begin
                        nxt.scl_level = 1'b0;
                        nxt.phase     = PH_IDLE;
                        done          = 1'b1;
                    end
                    else if (cur.poll_count >= cfg.ack_poll_limit)
                    begin
                        // timeout: flag and run a stop
                        nxt.error_flag  = 1'b1;
                        nxt.scl_level   = 1'b0;
                        nxt.sda_level   = 1'b0;
                        nxt.delay_count = unit_delay(UNITS_LONG, cfg.ticks_per_unit);
                        nxt.phase       = PH_SP1;
                    end
                    else
                    begin
                        nxt.poll_count = cur.poll_count + 8'd1;
                    end
                end
                PH_RD_HIGH:
                begin
                    nxt.scl_level   = 1'b1;
                    nxt.delay_count = unit_delay(UNITS_MID, cfg.ticks_per_unit);
                    nxt.phase       = PH_RD_SAMPLE + off;
                end
                PH_RD_SAMPLE:
                begin
                    nxt.shift       = {cur.shift[6:0], in_word.sda_in};
                    nxt.delay_count = unit_delay(UNITS_SHORT, cfg.ticks_per_unit);
                    nxt.phase       = PH_RD_LOW + off;
                end
                PH_RD_LOW:
                begin
                    nxt.scl_level = 1'b0;
                    nxt.bit_count = bits_inc;
                    if (bits_inc < 4'd8)
                    begin
                        nxt.delay_count = unit_delay(UNITS_LONG, cfg.ticks_per_unit);
                        nxt.phase       = PH_RD_HIGH + off;
                    end
                    else
                    begin
                        nxt.delay_count = unit_delay(UNITS_SHORT, cfg.ticks_per_unit);
                        nxt.phase       = PH_AK_DATA + off;
                    end
                end
                PH_AK_DATA:
                begin
                    nxt.sda_level   = nack;
                    nxt.delay_count = unit_delay(UNITS_MID, cfg.ticks_per_unit);
                    nxt.phase       = PH_AK_HIGH + off;
                end
                PH_AK_HIGH:
                begin
                    nxt.scl_level   = 1'b1;
                    nxt.delay_count = unit_delay(UNITS_LONG, cfg.ticks_per_unit);
                    nxt.phase       = PH_AK_LOW + off;
                end
                PH_AK_LOW:
                begin
                    nxt.scl_level = 1'b0;
                    nxt.phase     = PH_IDLE;
                    done          = 1'b1;
                    rx            = cur.shift;
                end
                default:
                begin
                    nxt.phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        res.scl_out   = nxt.scl_level;
        res.sda_out   = nxt.sda_level;
        res.busy_res  = (nxt.phase != PH_IDLE);
        res.done_res  = done;
        res.rx_byte   = rx;
        res.ack_error = nxt.error_flag;
    end

endmodule

// ===== src/i2cms_checker.sv =====
// port-level checks of the i2c master bit sequencer and their binding
module i2cms_checker
    import i2cms_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_data
);

    // a held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output word changed");

    // input backpressure only comes from a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_stall && out_valid)
        else $error("input stalled without output stall");

    // a finished sequence leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.busy_res)
        else $error("done reported while busy");

    // received data only shows on a done word
    a_rx_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.rx_byte != 8'd0) |-> out_data.done_res)
        else $error("rx byte without done");

    // an input word accepted while the result register is empty is followed by a result word
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |-> ##2 out_valid)
        else $error("result word missing");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== tb/i2c_master_bit_sequencer_test.sv =====
// self-checking testbench for the i2c master bit sequencer: directed rows, then random traffic
module i2c_master_bit_sequencer_test;
    import i2cms_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int RANDOM_ITEMS  = 300;
    localparam int PHASE_ITEMS   = 60;
    localparam int N_ROWS        = 24;
    localparam int NEVER_ACK     = 2047;
    localparam int RANDOM_SDA    = -1;

    // command codes the sequencer has no use for
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

    localparam out_word_t NO_WORD = '0;
    localparam out_word_t LINES_FREE = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
                                         done_res: 1'b0, rx_byte: 8'h00, ack_error: 1'b0};
    localparam out_word_t LINES_FREE_ERR = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
                                             done_res: 1'b0, rx_byte: 8'h00, ack_error: 1'b1};
    localparam out_word_t START_TAKEN = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b1,
                                          done_res: 1'b0, rx_byte: 8'h00, ack_error: 1'b0};
    localparam out_word_t STOP_TAKEN = '{scl_out: 1'b0, sda_out: 1'b0, busy_res: 1'b1,
                                         done_res: 1'b0, rx_byte: 8'h00, ack_error: 1'b0};

    typedef struct packed {
        logic [7:0]  tpu;
        logic [7:0]  lim;
        logic [2:0]  cmd;
        logic [7:0]  tx;
        logic [11:0] highs;
        logic        chk;
        out_word_t   want;
    } row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_word_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_word_t  out_data;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data  = 8'd0;

    // sequencer image kept by the predictor
    logic [PHASE_W-1:0] mdl_phase = PH_IDLE;
    logic [3:0]         mdl_bits  = 4'd0;
    logic [7:0]         mdl_shift = 8'd0;
    logic [DELAY_W-1:0] mdl_delay = '0;
    logic [7:0]         mdl_polls = 8'd0;
    logic               mdl_scl   = 1'b1;
    logic               mdl_sda   = 1'b1;
    logic               mdl_err   = 1'b0;
    logic [7:0]         cfg_tpu   = TICKS_PER_UNIT_RESET;
    logic [7:0]         cfg_limit = ACK_POLL_LIMIT_RESET;

    out_word_t  expected_words[$];
    logic [2:0] pending_cmds[$];
    int         ack_highs   = 0;
    int         items_sent  = 0;
    int         results_seen = 0;
    int         mismatches  = 0;
    int         rx_hold     = 0;
    bit         idle_on     = 1'b0;

    i2c_master_bit_sequencer uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

    function automatic void hold_for(input logic [2:0] units, input logic [PHASE_W-1:0] next);
        mdl_delay = DELAY_W'(int'(units) * int'(cfg_tpu));
        mdl_phase = next;
    endfunction

    function automatic bit seq_idle();
        return mdl_phase == PH_IDLE && mdl_delay == '0;
    endfunction

    // advance the sequencer image by one tick and return the word it should produce
    function automatic out_word_t predict_tick(input in_word_t w);
        out_word_t          r;
        logic               done;
        logic [7:0]         rx;
        logic               nack;
        logic [PHASE_W-1:0] off;
        logic [PHASE_W-1:0] base;
        done = 1'b0;
        rx = 8'd0;
        if (mdl_delay != '0)
        begin
            mdl_delay = mdl_delay - 1'b1;
        end
        else if (mdl_phase == PH_IDLE)
        begin
            if (w.command >= CMD_START && w.command <= CMD_READ_NACK)
                mdl_err = 1'b0;
            case (w.command)
                CMD_START:
                begin
                    mdl_sda = 1'b1;
                    mdl_scl = 1'b1;
                    hold_for(UNITS_LONG, PH_ST1);
                end
                CMD_STOP:
                begin
                    mdl_scl = 1'b0;
                    mdl_sda = 1'b0;
                    hold_for(UNITS_LONG, PH_SP1);
                end
                CMD_WRITE:
                begin
                    mdl_shift = w.tx_byte;
                    mdl_bits = 4'd0;
                    hold_for(UNITS_SHORT, PH_WR_DATA);
                end
                CMD_READ_ACK, CMD_READ_NACK:
                begin
                    mdl_sda = 1'b1;
                    mdl_shift = 8'd0;
                    mdl_bits = 4'd0;
                    hold_for(UNITS_LONG, (w.command == CMD_READ_NACK) ?
                             PH_RD_HIGH + NACK_OFFSET : PH_RD_HIGH);
                end
                default: ;
            endcase
        end
        else
        begin
            // nack reads run the read phases shifted up by the offset
            nack = mdl_phase >= PH_RD_HIGH + NACK_OFFSET;
            off = nack ? NACK_OFFSET : '0;
            base = mdl_phase - off;
            case (base)
                PH_ST1:
                begin
                    mdl_sda = 1'b0;
                    hold_for(UNITS_LONG, PH_ST2);
                end
                PH_ST2:
                begin
                    mdl_scl = 1'b0;
                    mdl_phase = PH_IDLE;
                    done = 1'b1;
                end
                PH_SP1:
                begin
                    mdl_scl = 1'b1;
                    hold_for(UNITS_LONG, PH_SP2);
                end
                PH_SP2:
                begin
                    mdl_sda = 1'b1;
                    hold_for(UNITS_LONG, PH_SP3);
                end
                PH_SP3:
                begin
                    mdl_phase = PH_IDLE;
                    done = 1'b1;
                end
                PH_WR_DATA:
                begin
                    mdl_sda = mdl_shift[7];
                    mdl_shift = {mdl_shift[6:0], 1'b0};
                    hold_for(UNITS_MID, PH_WR_HIGH);
                end
                PH_WR_HIGH:
                begin
                    mdl_scl = 1'b1;
                    hold_for(UNITS_LONG, PH_WR_LOW);
                end
                PH_WR_LOW:
                begin
                    mdl_scl = 1'b0;
                    mdl_bits = mdl_bits + 1'b1;
                    if (mdl_bits < 4'd8)
                    begin
                        hold_for(UNITS_SHORT, PH_WR_DATA);
                    end
                    else
                    begin
                        mdl_sda = 1'b1;
                        hold_for(UNITS_LONG, PH_ACK_HIGH);
                    end
                end
                PH_ACK_HIGH:
                begin
                    mdl_scl = 1'b1;
                    mdl_polls = 8'd0;
                    hold_for(UNITS_SHORT, PH_ACK_POLL);
                end
                PH_ACK_POLL:
                begin
                    if (!w.sda_in)
                    begin
                        mdl_scl = 1'b0;
                        mdl_phase = PH_IDLE;
                        done = 1'b1;
                    end
                    else if (mdl_polls >= cfg_limit)
                    begin
                        // slave never answered: flag it and release the bus with a stop
                        mdl_err = 1'b1;
                        mdl_scl = 1'b0;
                        mdl_sda = 1'b0;
                        hold_for(UNITS_LONG, PH_SP1);
                    end
                    else
                    begin
                        mdl_polls = mdl_polls + 1'b1;
                    end
                end
                PH_RD_HIGH:
                begin
                    mdl_scl = 1'b1;
                    hold_for(UNITS_MID, PH_RD_SAMPLE + off);
                end
                PH_RD_SAMPLE:
                begin
                    mdl_shift = {mdl_shift[6:0], w.sda_in};
                    hold_for(UNITS_SHORT, PH_RD_LOW + off);
                end
                PH_RD_LOW:
                begin
                    mdl_scl = 1'b0;
                    mdl_bits = mdl_bits + 1'b1;
                    if (mdl_bits < 4'd8)
                        hold_for(UNITS_LONG, PH_RD_HIGH + off);
                    else
                        hold_for(UNITS_SHORT, PH_AK_DATA + off);
                end
                PH_AK_DATA:
                begin
                    mdl_sda = nack;
                    hold_for(UNITS_MID, PH_AK_HIGH + off);
                end
                PH_AK_HIGH:
                begin
                    mdl_scl = 1'b1;
                    hold_for(UNITS_LONG, PH_AK_LOW + off);
                end
                PH_AK_LOW:
                begin
                    mdl_scl = 1'b0;
                    mdl_phase = PH_IDLE;
                    done = 1'b1;
                    rx = mdl_shift;
                end
                default: mdl_phase = PH_IDLE;
            endcase
        end
        r.scl_out = mdl_scl;
        r.sda_out = mdl_sda;
        r.busy_res = mdl_phase != PH_IDLE;
        r.done_res = done;
        r.rx_byte = rx;
        r.ack_error = mdl_err;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("result %0d: %s is 0x%0h, expected 0x%0h", results_seen, field, got, want);
        mismatches++;
    endtask

    task automatic check_result(input out_word_t got);
        out_word_t want;
        results_seen++;
        if (expected_words.size() == 0)
        begin
            report_mismatch("word with nothing expected", 8'(got), 8'd0);
            return;
        end
        want = expected_words.pop_front();
        if (got.scl_out !== want.scl_out)
            report_mismatch("scl_out", 8'(got.scl_out), 8'(want.scl_out));
        if (got.sda_out !== want.sda_out)
            report_mismatch("sda_out", 8'(got.sda_out), 8'(want.sda_out));
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        if (got.done_res !== want.done_res)
            report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
        if (got.rx_byte !== want.rx_byte)
            report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
        if (got.ack_error !== want.ack_error)
            report_mismatch("ack_error", 8'(got.ack_error), 8'(want.ack_error));
    endtask

    // result side: check each accepted word, then, with idle gaps on, hold off for a drawn number of cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                check_result(out_data);
                rx_hold = idle_on ? $urandom_range(15, 0) : 0;
            end
            out_stall <= (rx_hold != 0);
            if (rx_hold != 0)
                rx_hold--;
        end
    end

    task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_word);
        int        gap;
        out_word_t predicted;
        gap = idle_on ? $urandom_range(15, 0) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_tick(w);
        expected_words.push_back(typed ? typed_word : predicted);
        items_sent++;
    endtask

    // one tick while the sequencer is busy: command is noise, sda follows the ack plan while polling
    task automatic fill_tick();
        in_word_t w;
        w.command = 3'($urandom_range(7, 0));
        w.tx_byte = 8'($urandom);
        w.sda_in = 1'($urandom);
        if (mdl_phase == PH_ACK_POLL && mdl_delay == '0 && ack_highs != RANDOM_SDA)
            w.sda_in = int'(mdl_polls) < ack_highs;
        send_word(w, 1'b0, NO_WORD);
    endtask

    task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx, input int highs,
                               input bit typed, input out_word_t typed_word);
        in_word_t w;
        while (!seq_idle())
            fill_tick();
        ack_highs = highs;
        w.command = cmd;
        w.tx_byte = tx;
        w.sda_in = 1'($urandom);
        send_word(w, typed, typed_word);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] tpu, input logic [7:0] lim);
        while (!seq_idle())
            fill_tick();
        settle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_TICKS_PER_UNIT;
        cfg_data <= tpu;
        @(posedge clk);
        cfg_index <= CFG_ACK_POLL_LIMIT;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_tpu = tpu;
        cfg_limit = lim;
    endtask

    // mostly whole transactions, sometimes a few loose commands
    task automatic plan_commands();
        int n;
        int k;
        if ($urandom_range(4, 0) != 0)
        begin
            pending_cmds.push_back(CMD_START);
            n = $urandom_range(3, 1);
            repeat (n) pending_cmds.push_back(CMD_WRITE);
            n = $urandom_range(2, 0);
            for (k = 0; k < n; k++)
                pending_cmds.push_back((k == n - 1) ? CMD_READ_NACK : CMD_READ_ACK);
            if ($urandom_range(9, 0) != 0)
                pending_cmds.push_back(CMD_STOP);
        end
        else
        begin
            n = $urandom_range(3, 1);
            repeat (n) pending_cmds.push_back(3'($urandom_range(7, 0)));
        end
    endtask

    // number of high polls the slave holds off before it acknowledges, or the random sda marker
    function automatic int pick_highs();
        int r;
        r = $urandom_range(15, 0);
        if (r < 9)
            return $urandom_range(3, 0);
        if (r < 11)
            return NEVER_ACK;
        if (r < 13)
            return RANDOM_SDA;
        return int'(cfg_limit) + int'($urandom_range(1, 0));
    endfunction

    function automatic row_t directed_row(input int idx);
        case (idx)
            0:  return '{8'd50,  8'd250, CMD_NONE,      8'h00, 12'd0,    1'b1, LINES_FREE};
            1:  return '{8'd50,  8'd250, CMD_START,     8'h00, 12'd0,    1'b1, START_TAKEN};
            2:  return '{8'd0,   8'd0,   CMD_WRITE,     8'hFF, 12'd0,    1'b0, NO_WORD};
            3:  return '{8'd0,   8'd0,   CMD_WRITE,     8'h00, 12'd1,    1'b0, NO_WORD};
            4:  return '{8'd0,   8'd0,   CMD_NONE,      8'h00, 12'd0,    1'b1, LINES_FREE_ERR};
            5:  return '{8'd0,   8'd0,   CMD_UNUSED_6,  8'h00, 12'd0,    1'b1, LINES_FREE_ERR};
            6:  return '{8'd0,   8'd0,   CMD_UNUSED_7,  8'hFF, 12'd0,    1'b1, LINES_FREE_ERR};
            7:  return '{8'd0,   8'd0,   CMD_START,     8'h00, 12'd0,    1'b1, START_TAKEN};
            8:  return '{8'd0,   8'd255, CMD_WRITE,     8'hA5, 12'd3,    1'b0, NO_WORD};
            9:  return '{8'd0,   8'd255, CMD_READ_ACK,  8'h00, 12'd0,    1'b0, NO_WORD};
            10: return '{8'd0,   8'd255, CMD_READ_NACK, 8'h00, 12'd0,    1'b0, NO_WORD};
            11: return '{8'd0,   8'd255, CMD_STOP,      8'h00, 12'd0,    1'b1, STOP_TAKEN};
            12: return '{8'd1,   8'd255, CMD_START,     8'h00, 12'd0,    1'b0, NO_WORD};
            13: return '{8'd1,   8'd255, CMD_WRITE,     8'h5A, 12'd0,    1'b0, NO_WORD};
            14: return '{8'd1,   8'd255, CMD_WRITE,     8'h80, 12'd2047, 1'b0, NO_WORD};
            15: return '{8'd1,   8'd1,   CMD_START,     8'h00, 12'd0,    1'b0, NO_WORD};
            16: return '{8'd1,   8'd1,   CMD_WRITE,     8'h01, 12'd1,    1'b0, NO_WORD};
            17: return '{8'd1,   8'd1,   CMD_WRITE,     8'h7F, 12'd2,    1'b0, NO_WORD};
            18: return '{8'd1,   8'd1,   CMD_READ_NACK, 8'h00, 12'd0,    1'b0, NO_WORD};
            19: return '{8'd3,   8'd250, CMD_START,     8'h00, 12'd0,    1'b1, START_TAKEN};
            20: return '{8'd3,   8'd250, CMD_STOP,      8'h00, 12'd0,    1'b1, STOP_TAKEN};
            21: return '{8'd2,   8'd3,   CMD_STOP,      8'h00, 12'd0,    1'b1, STOP_TAKEN};
            22: return '{8'd2,   8'd3,   CMD_READ_ACK,  8'hFF, 12'd0,    1'b0, NO_WORD};
            default: return '{8'd2, 8'd3, CMD_WRITE,    8'hFF, 12'd3,    1'b0, NO_WORD};
        endcase
    endfunction

    initial
    begin
        row_t       row;
        int         mark;
        int         budget;
        int         p;
        int         i;
        logic [7:0] tpu;
        logic [7:0] lim;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; the first ones run on the reset configuration
        for (i = 0; i < N_ROWS; i++)
        begin
            row = directed_row(i);
            if (row.tpu != cfg_tpu || row.lim != cfg_limit)
                set_config(row.tpu, row.lim);
            idle_on = cfg_tpu < 8'd8;
            run_command(row.cmd, row.tx, int'(row.highs), row.chk, row.want);
        end

        mark = items_sent;
        p = 0;
        while (items_sent - mark < RANDOM_ITEMS)
        begin
            case ($urandom_range(5, 0))
                0, 1: tpu = 8'd0;
                2, 3: tpu = 8'd1;
                4: tpu = 8'd2;
                default: tpu = 8'($urandom_range(5, 0));
            endcase
            case ($urandom_range(4, 0))
                0: lim = 8'd0;
                1: lim = 8'd1;
                2: lim = 8'd255;
                3: lim = 8'($urandom_range(20, 0));
                default: lim = 8'($urandom_range(6, 2));
            endcase
            set_config(tpu, lim);
            idle_on = (p % 3) != 1;
            budget = items_sent + PHASE_ITEMS;
            while (items_sent < budget && items_sent - mark < RANDOM_ITEMS)
            begin
                if (pending_cmds.size() == 0)
                    plan_commands();
                // now and then let the result side run dry mid-stream
                if ($urandom_range(39, 0) == 0)
                    settle();
                run_command(pending_cmds.pop_front(), 8'($urandom), pick_highs(), 1'b0,
                            NO_WORD);
            end
            p++;
        end

        settle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
